>>> rtl/core/time_of_day_alu_unit_defines.svh
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: assertion macros
// Shared concurrent checks for the result channel and the pipeline.
// ---------------------------------------------------------------------------
`ifndef TIME_OF_DAY_ALU_UNIT_DEFINES_SVH
`define TIME_OF_DAY_ALU_UNIT_DEFINES_SVH

// A property that must hold whenever a result item is offered.
`define TOD_RESULT_CHECK(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) \
      rsp_valid |-> (cond)) \
   else $error("time-of-day unit: result item check failed");

// A property that must hold in the cycle after the trigger, outside reset.
`define TOD_NEXT_CHECK(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) \
      (trig) |=> (cond)) \
   else $error("time-of-day unit: pipeline check failed");

`endif

>>> rtl/core/tod_alu_pkg.sv
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: package
// Commands, constants and the item records that pass between the stages.
// ---------------------------------------------------------------------------
package tod_alu_pkg;

   localparam int SECS_WIDTH  = 17;
   localparam int CNT_WIDTH   = 32;
   localparam int CNT_LOW     = 7;
   localparam int CNT_Q_WIDTH = CNT_WIDTH - CNT_LOW;
   localparam int EST_WIDTH   = 16;
   localparam int REM_WIDTH   = 11;
   localparam int REMH_WIDTH  = 12;

   localparam logic [SECS_WIDTH-1:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [SECS_WIDTH-1:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [SECS_WIDTH-1:0] SECS_PER_MIN  = 17'd60;
   localparam logic [4:0]            MAX_HOUR      = 5'd23;
   localparam logic [5:0]            MAX_MIN_SEC   = 6'd59;

   // The day is 128 * 675 seconds, so the count is reduced modulo 675 from bit 7 up.
   localparam logic [9:0]  CNT_DIV     = 10'd675;
   localparam logic [25:0] CNT_RECIP   = 26'd50903316;
   localparam int          CNT_SHIFT   = 35;
   localparam logic [15:0] HOUR_RECIP  = 16'd37283;
   localparam int          HOUR_SHIFT  = 27;
   localparam logic [12:0] MIN_RECIP   = 13'd4370;
   localparam int          MIN_SHIFT   = 18;

   localparam int FRONT_STAGES = 3;
   localparam int SPLIT_STAGES = 4;
   localparam int NUM_STAGES   = FRONT_STAGES + 1 + SPLIT_STAGES;

   typedef enum logic [2:0] {
      CMD_TO_SECONDS   = 3'd0,
      CMD_FROM_SECONDS = 3'd1,
      CMD_ADD          = 3'd2,
      CMD_SUBTRACT     = 3'd3,
      CMD_DURATION     = 3'd4,
      CMD_COMPARE      = 3'd5
   } tod_cmd_type;

   typedef logic [FRONT_STAGES-1:0] front_en_type;
   typedef logic [SPLIT_STAGES-1:0] split_en_type;

   typedef struct packed {
      tod_cmd_type           command;
      logic [SECS_WIDTH-1:0] secs_a;
      logic [SECS_WIDTH-1:0] secs_b;
      logic [SECS_WIDTH-1:0] secs_cnt;
      logic                  equal;
      logic                  less;
      logic                  greater;
      logic                  valid_a;
   } front_type;

   typedef struct packed {
      logic [SECS_WIDTH-1:0] secs;
      logic                  equal;
      logic                  less;
      logic                  greater;
      logic                  valid_a;
   } exec_type;

   typedef struct packed {
      logic [4:0]            hour;
      logic [5:0]            minute;
      logic [5:0]            second;
      logic [SECS_WIDTH-1:0] secs;
      logic                  equal;
      logic                  less;
      logic                  greater;
      logic                  valid_a;
   } result_type;

   function automatic logic [SECS_WIDTH-1:0] hms_raw(input logic [4:0] hour,
                                                     input logic [5:0] minute,
                                                     input logic [5:0] second);
      return SECS_WIDTH'(hour) * SECS_PER_HOUR + SECS_WIDTH'(minute) * SECS_PER_MIN
             + SECS_WIDTH'(second);
   endfunction

   // The raw sum stays below two days, so one subtraction reduces it.
   function automatic logic [SECS_WIDTH-1:0] day_reduce(input logic [SECS_WIDTH-1:0] raw);
      return (raw >= SECS_PER_DAY) ? raw - SECS_PER_DAY : raw;
   endfunction

endpackage

>>> rtl/core/tod_alu_front.sv
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: operand stages
// Turns both times into seconds of the day and reduces the count modulo one day.
// ---------------------------------------------------------------------------
module tod_alu_front import tod_alu_pkg::*; (
   input  logic                 clock,
   input  front_en_type         stage_en,
   input  logic [2:0]           command,
   input  logic [4:0]           hour_a,
   input  logic [5:0]           minute_a,
   input  logic [5:0]           second_a,
   input  logic [4:0]           hour_b,
   input  logic [5:0]           minute_b,
   input  logic [5:0]           second_b,
   input  logic [CNT_WIDTH-1:0] count,
   output front_type            operands
);

   tod_cmd_type              cmd0_ff, cmd1_ff;
   logic [SECS_WIDTH-1:0]    raw_a_ff, raw_b_ff, secs_a1_ff, secs_b1_ff;
   logic [CNT_LOW-1:0]       low0_ff, low1_ff;
   logic [CNT_Q_WIDTH-1:0]   quot_ff;
   logic [EST_WIDTH-1:0]     est_ff;
   logic [REM_WIDTH-1:0]     rem_ff;
   logic                     valid_a0_ff, valid_a1_ff;
   front_type                operands_ff;

   logic [CNT_Q_WIDTH+25:0]  est_prod_in;
   logic [EST_WIDTH-1:0]     est_in;
   logic [CNT_Q_WIDTH-1:0]   back_in;
   logic [REM_WIDTH-1:0]     rem_in;
   logic [9:0]               rem_fix_in;
   front_type                operands_in;

   always_comb begin
      est_prod_in = (CNT_Q_WIDTH+26)'(count[CNT_WIDTH-1:CNT_LOW]) * (CNT_Q_WIDTH+26)'(CNT_RECIP);
      est_in      = est_prod_in[CNT_SHIFT+EST_WIDTH-1:CNT_SHIFT];
      back_in     = CNT_Q_WIDTH'(est_ff) * CNT_Q_WIDTH'(CNT_DIV);
      rem_in      = REM_WIDTH'(quot_ff - back_in);
      rem_fix_in  = (rem_ff >= REM_WIDTH'(CNT_DIV)) ? 10'(rem_ff - REM_WIDTH'(CNT_DIV))
                                                    : rem_ff[9:0];
      operands_in.command  = cmd1_ff;
      operands_in.secs_a   = secs_a1_ff;
      operands_in.secs_b   = secs_b1_ff;
      operands_in.secs_cnt = {rem_fix_in, low1_ff};
      operands_in.equal    = (secs_a1_ff == secs_b1_ff);
      operands_in.less     = (secs_a1_ff < secs_b1_ff);
      operands_in.greater  = (secs_a1_ff > secs_b1_ff);
      operands_in.valid_a  = valid_a1_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         cmd0_ff     <= tod_cmd_type'(command);
         raw_a_ff    <= hms_raw(hour_a, minute_a, second_a);
         raw_b_ff    <= hms_raw(hour_b, minute_b, second_b);
         low0_ff     <= count[CNT_LOW-1:0];
         quot_ff     <= count[CNT_WIDTH-1:CNT_LOW];
         est_ff      <= est_in;
         valid_a0_ff <= (hour_a <= MAX_HOUR) && (minute_a <= MAX_MIN_SEC)
                        && (second_a <= MAX_MIN_SEC);
      end
      if (stage_en[1]) begin
         cmd1_ff     <= cmd0_ff;
         secs_a1_ff  <= day_reduce(raw_a_ff);
         secs_b1_ff  <= day_reduce(raw_b_ff);
         low1_ff     <= low0_ff;
         rem_ff      <= rem_in;
         valid_a1_ff <= valid_a0_ff;
      end
      if (stage_en[2]) begin
         operands_ff <= operands_in;
      end
   end

   assign operands = operands_ff;

endmodule

>>> rtl/core/tod_alu_exec.sv
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: command stage
// Forms the resulting seconds of the day for the command of the item.
// ---------------------------------------------------------------------------
module tod_alu_exec import tod_alu_pkg::*; (
   input  logic      clock,
   input  logic      stage_en,
   input  front_type operands,
   output exec_type  outcome
);

   exec_type                outcome_ff, outcome_in;
   logic [SECS_WIDTH:0]     sum_in;

   always_comb begin
      sum_in             = (SECS_WIDTH+1)'(operands.secs_a) + (SECS_WIDTH+1)'(operands.secs_cnt);
      outcome_in.secs    = '0;
      outcome_in.equal   = 1'b0;
      outcome_in.less    = 1'b0;
      outcome_in.greater = 1'b0;
      outcome_in.valid_a = operands.valid_a;
      case (operands.command)
         CMD_TO_SECONDS: begin
            outcome_in.secs = operands.secs_a;
         end
         CMD_FROM_SECONDS: begin
            outcome_in.secs = operands.secs_cnt;
         end
         CMD_ADD: begin
            outcome_in.secs = (sum_in >= (SECS_WIDTH+1)'(SECS_PER_DAY))
                              ? SECS_WIDTH'(sum_in - (SECS_WIDTH+1)'(SECS_PER_DAY))
                              : sum_in[SECS_WIDTH-1:0];
         end
         CMD_SUBTRACT: begin
            outcome_in.secs = (operands.secs_a >= operands.secs_cnt)
                              ? operands.secs_a - operands.secs_cnt
                              : operands.secs_a + (SECS_PER_DAY - operands.secs_cnt);
         end
         CMD_DURATION: begin
            outcome_in.secs = operands.greater
                              ? operands.secs_b + (SECS_PER_DAY - operands.secs_a)
                              : operands.secs_b - operands.secs_a;
         end
         CMD_COMPARE: begin
            outcome_in.secs    = operands.secs_a;
            outcome_in.equal   = operands.equal;
            outcome_in.less    = operands.less;
            outcome_in.greater = operands.greater;
         end
         default: begin
            outcome_in.secs = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         outcome_ff <= outcome_in;
      end
   end

   assign outcome = outcome_ff;

endmodule

>>> rtl/core/tod_alu_split.sv
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: split stages
// Takes seconds of the day apart into hours, minutes and seconds.
// ---------------------------------------------------------------------------
module tod_alu_split import tod_alu_pkg::*; (
   input  logic         clock,
   input  split_en_type stage_en,
   input  exec_type     outcome,
   output result_type   result
);

   exec_type                 carry0_ff, carry1_ff, carry2_ff;
   logic [4:0]               hour0_ff, hour1_ff, hour2_ff;
   logic [REMH_WIDTH-1:0]    remh1_ff, remh2_ff;
   logic [5:0]               minute2_ff;
   result_type               result_ff, result_in;

   logic [SECS_WIDTH+15:0]   hour_prod_in;
   logic [SECS_WIDTH-1:0]    hour_back_in;
   logic [REMH_WIDTH+12:0]   min_prod_in;
   logic [REMH_WIDTH-1:0]    min_back_in;

   always_comb begin
      hour_prod_in = (SECS_WIDTH+16)'(outcome.secs) * (SECS_WIDTH+16)'(HOUR_RECIP);
      hour_back_in = SECS_WIDTH'(hour0_ff) * SECS_PER_HOUR;
      min_prod_in  = (REMH_WIDTH+13)'(remh1_ff) * (REMH_WIDTH+13)'(MIN_RECIP);
      min_back_in  = REMH_WIDTH'(minute2_ff) * REMH_WIDTH'(SECS_PER_MIN);
      result_in.hour    = hour2_ff;
      result_in.minute  = minute2_ff;
      result_in.second  = 6'(remh2_ff - min_back_in);
      result_in.secs    = carry2_ff.secs;
      result_in.equal   = carry2_ff.equal;
      result_in.less    = carry2_ff.less;
      result_in.greater = carry2_ff.greater;
      result_in.valid_a = carry2_ff.valid_a;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         carry0_ff <= outcome;
         hour0_ff  <= hour_prod_in[HOUR_SHIFT+4:HOUR_SHIFT];
      end
      if (stage_en[1]) begin
         carry1_ff <= carry0_ff;
         hour1_ff  <= hour0_ff;
         remh1_ff  <= REMH_WIDTH'(carry0_ff.secs - hour_back_in);
      end
      if (stage_en[2]) begin
         carry2_ff  <= carry1_ff;
         hour2_ff   <= hour1_ff;
         remh2_ff   <= remh1_ff;
         minute2_ff <= min_prod_in[MIN_SHIFT+5:MIN_SHIFT];
      end
      if (stage_en[3]) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> rtl/core/time_of_day_alu_unit.sv
// Throughput: one item per cycle while results are not stalled; the eight
// register stages advance together where they can, and a stalled result holds
// only the stages behind it. Reset clears every stage valid bit; the stage
// data registers are not reset.
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit
// Converts, adds, subtracts, measures and compares times of day in hh:mm:ss.
// ---------------------------------------------------------------------------
`include "time_of_day_alu_unit_defines.svh"

module time_of_day_alu_unit import tod_alu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [2:0]            req_command,
   input  logic [4:0]            req_hour_a,
   input  logic [5:0]            req_minute_a,
   input  logic [5:0]            req_second_a,
   input  logic [4:0]            req_hour_b,
   input  logic [5:0]            req_minute_b,
   input  logic [5:0]            req_second_b,
   input  logic [CNT_WIDTH-1:0]  req_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [4:0]            rsp_hour_out,
   output logic [5:0]            rsp_minute_out,
   output logic [5:0]            rsp_second_out,
   output logic [SECS_WIDTH-1:0] rsp_seconds_total,
   output logic                  rsp_is_equal,
   output logic                  rsp_is_less,
   output logic                  rsp_is_greater,
   output logic                  rsp_valid_a
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in, ready;
   logic                  in_acc, out_acc;
   front_type             operands;
   exec_type              outcome;
   result_type            result;

   always_comb begin
      ready[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   tod_alu_front u_front (
      .clock    (clock),
      .stage_en (ready[FRONT_STAGES-1:0]),
      .command  (req_command),
      .hour_a   (req_hour_a),
      .minute_a (req_minute_a),
      .second_a (req_second_a),
      .hour_b   (req_hour_b),
      .minute_b (req_minute_b),
      .second_b (req_second_b),
      .count    (req_count),
      .operands (operands)
   );

   tod_alu_exec u_exec (
      .clock    (clock),
      .stage_en (ready[FRONT_STAGES]),
      .operands (operands),
      .outcome  (outcome)
   );

   tod_alu_split u_split (
      .clock    (clock),
      .stage_en (ready[NUM_STAGES-1:FRONT_STAGES+1]),
      .outcome  (outcome),
      .result   (result)
   );

   assign req_stall         = !ready[0];
   assign rsp_valid         = valid_ff[NUM_STAGES-1];
   assign in_acc            = req_valid && !req_stall;
   assign out_acc           = rsp_valid && !rsp_stall;
   assign rsp_hour_out      = result.hour;
   assign rsp_minute_out    = result.minute;
   assign rsp_second_out    = result.second;
   assign rsp_seconds_total = result.secs;
   assign rsp_is_equal      = result.equal;
   assign rsp_is_less       = result.less;
   assign rsp_is_greater    = result.greater;
   assign rsp_valid_a       = result.valid_a;

   `TOD_RESULT_CHECK(a_fields_in_range, (rsp_hour_out <= MAX_HOUR) && (rsp_minute_out <= MAX_MIN_SEC) && (rsp_second_out <= MAX_MIN_SEC) && (rsp_seconds_total < SECS_PER_DAY))
   `TOD_RESULT_CHECK(a_split_consistent, rsp_seconds_total == SECS_WIDTH'(rsp_hour_out) * SECS_PER_HOUR + SECS_WIDTH'(rsp_minute_out) * SECS_PER_MIN + SECS_WIDTH'(rsp_second_out))
   `TOD_RESULT_CHECK(a_one_flag, $countones({rsp_is_equal, rsp_is_less, rsp_is_greater}) <= 1)
   `TOD_NEXT_CHECK(a_items_kept, !reset, $countones(valid_ff) == $countones($past(valid_ff)) + int'($past(in_acc)) - int'($past(out_acc)))

endmodule

>>> verif/time_of_day_alu_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Time-of-day arithmetic unit: testbench
// A table of directed items covers the field extremes, every command, the
// unused command codes and out-of-range times. Random items follow. Results
// are checked field by field against the table or a predictor, in order, under
// random gaps and stalls on both channels and one long result hold-off.
// ---------------------------------------------------------------------------
module time_of_day_alu_unit_tb;
   import tod_alu_pkg::*;

   localparam int unsigned DAY_SECONDS    = 86400;
   localparam int unsigned HOUR_SECONDS   = 3600;
   localparam int unsigned MINUTE_SECONDS = 60;
   localparam int unsigned HOLD_CYCLES    = 80;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int          NUM_DIRECTED   = 25;

   // Command codes that the unit does not define.
   localparam logic [2:0] CMD_SPARE_SIX   = 3'd6;
   localparam logic [2:0] CMD_SPARE_SEVEN = 3'd7;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  hour_a;
      logic [5:0]  minute_a;
      logic [5:0]  second_a;
      logic [4:0]  hour_b;
      logic [5:0]  minute_b;
      logic [5:0]  second_b;
      logic [31:0] count;
   } tod_item_type;

   typedef struct packed {
      tod_item_type item;
      logic         typed;
      result_type   want;
   } tod_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_command = '0;
   logic [4:0]            req_hour_a = '0;
   logic [5:0]            req_minute_a = '0;
   logic [5:0]            req_second_a = '0;
   logic [4:0]            req_hour_b = '0;
   logic [5:0]            req_minute_b = '0;
   logic [5:0]            req_second_b = '0;
   logic [CNT_WIDTH-1:0]  req_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [4:0]            rsp_hour_out;
   logic [5:0]            rsp_minute_out;
   logic [5:0]            rsp_second_out;
   logic [SECS_WIDTH-1:0] rsp_seconds_total;
   logic                  rsp_is_equal;
   logic                  rsp_is_less;
   logic                  rsp_is_greater;
   logic                  rsp_valid_a;

   result_type  expected_results[$];
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned items_sent = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned cycle_count = 0;
   bit          sender_gaps = 1'b1;
   bit          receiver_stalls = 1'b1;
   bit          hold_off_request = 1'b0;

   time_of_day_alu_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_hour_a        (req_hour_a),
      .req_minute_a      (req_minute_a),
      .req_second_a      (req_second_a),
      .req_hour_b        (req_hour_b),
      .req_minute_b      (req_minute_b),
      .req_second_b      (req_second_b),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hour_out      (rsp_hour_out),
      .rsp_minute_out    (rsp_minute_out),
      .rsp_second_out    (rsp_second_out),
      .rsp_seconds_total (rsp_seconds_total),
      .rsp_is_equal      (rsp_is_equal),
      .rsp_is_less       (rsp_is_less),
      .rsp_is_greater    (rsp_is_greater),
      .rsp_valid_a       (rsp_valid_a)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   tod_row_type directed_rows [NUM_DIRECTED] = '{
      '{'{CMD_TO_SECONDS, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_TO_SECONDS, 5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_TO_SECONDS, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
      '{'{CMD_TO_SECONDS, 5'd24, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
      '{'{CMD_TO_SECONDS, 5'd0, 6'd60, 6'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
      '{'{CMD_TO_SECONDS, 5'd0, 6'd0, 6'd60, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
      '{'{CMD_FROM_SECONDS, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_FROM_SECONDS, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd86400}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_FROM_SECONDS, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd86399}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_FROM_SECONDS, 5'd31, 6'd63, 6'd63, 5'd0, 6'd0, 6'd0, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{CMD_ADD, 5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 32'd1}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_ADD, 5'd12, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{CMD_SUBTRACT, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd1}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_SUBTRACT, 5'd1, 6'd0, 6'd0, 5'd0, 6'd0, 6'd0, 32'd86401}, 1'b0, '0},
      '{'{CMD_SUBTRACT, 5'd5, 6'd6, 6'd7, 5'd0, 6'd0, 6'd0, 32'hFFFFFFFF}, 1'b0, '0},
      '{'{CMD_DURATION, 5'd12, 6'd0, 6'd0, 5'd12, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_DURATION, 5'd0, 6'd0, 6'd1, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_DURATION, 5'd0, 6'd0, 6'd0, 5'd23, 6'd59, 6'd59, 32'd0}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_DURATION, 5'd10, 6'd20, 6'd30, 5'd8, 6'd0, 6'd0, 32'd0}, 1'b0, '0},
      '{'{CMD_COMPARE, 5'd12, 6'd34, 6'd56, 5'd12, 6'd34, 6'd56, 32'd0}, 1'b1,
        '{5'd12, 6'd34, 6'd56, 17'd45296, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{'{CMD_COMPARE, 5'd0, 6'd0, 6'd0, 5'd0, 6'd0, 6'd1, 32'd0}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b1, 1'b0, 1'b1}},
      '{'{CMD_COMPARE, 5'd23, 6'd59, 6'd59, 5'd0, 6'd0, 6'd0, 32'd0}, 1'b1,
        '{5'd23, 6'd59, 6'd59, 17'd86399, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{CMD_COMPARE, 5'd31, 6'd63, 6'd63, 5'd8, 6'd4, 6'd3, 32'd0}, 1'b0, '0},
      '{'{CMD_SPARE_SIX, 5'd31, 6'd63, 6'd63, 5'd23, 6'd59, 6'd59, 32'hFFFFFFFF}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{CMD_SPARE_SEVEN, 5'd1, 6'd2, 6'd3, 5'd4, 6'd5, 6'd6, 32'd12345}, 1'b1,
        '{5'd0, 6'd0, 6'd0, 17'd0, 1'b0, 1'b0, 1'b0, 1'b1}}
   };

   function automatic result_type predict_tod_result(input tod_item_type it);
      result_type  res;
      int unsigned secs_a;
      int unsigned secs_b;
      int unsigned reduced_count;
      int unsigned total;
      secs_a = (it.hour_a * HOUR_SECONDS + it.minute_a * MINUTE_SECONDS + it.second_a)
               % DAY_SECONDS;
      secs_b = (it.hour_b * HOUR_SECONDS + it.minute_b * MINUTE_SECONDS + it.second_b)
               % DAY_SECONDS;
      reduced_count = it.count % DAY_SECONDS;
      total = 0;
      res = '0;
      case (it.command)
         CMD_TO_SECONDS:   total = secs_a;
         CMD_FROM_SECONDS: total = reduced_count;
         CMD_ADD:          total = (secs_a + reduced_count) % DAY_SECONDS;
         CMD_SUBTRACT:     total = (secs_a + DAY_SECONDS - reduced_count) % DAY_SECONDS;
         CMD_DURATION:     total = (secs_a > secs_b) ? DAY_SECONDS + secs_b - secs_a
                                                     : secs_b - secs_a;
         CMD_COMPARE: begin
            total = secs_a;
            res.equal = (secs_a == secs_b);
            res.less = (secs_a < secs_b);
            res.greater = (secs_a > secs_b);
         end
         default: total = 0;
      endcase
      res.hour = 5'(total / HOUR_SECONDS);
      res.minute = 6'((total % HOUR_SECONDS) / MINUTE_SECONDS);
      res.second = 6'(total % MINUTE_SECONDS);
      res.secs = SECS_WIDTH'(total);
      res.valid_a = (it.hour_a <= 23) && (it.minute_a <= 59) && (it.second_a <= 59);
      return res;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned idle_length();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic tod_item_type random_tod_item();
      tod_item_type it;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      it.command = (pick < 5) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      if ($urandom_range(0, 3) == 0) begin
         it.hour_a = 5'($urandom);
         it.minute_a = 6'($urandom);
         it.second_a = 6'($urandom);
      end else begin
         it.hour_a = 5'($urandom_range(0, 23));
         it.minute_a = 6'($urandom_range(0, 59));
         it.second_a = 6'($urandom_range(0, 59));
      end
      it.hour_b = 5'($urandom_range(0, 23));
      it.minute_b = 6'($urandom_range(0, 59));
      it.second_b = 6'($urandom_range(0, 59));
      case ($urandom_range(0, 4))
         0: it.count = $urandom;
         1: it.count = $urandom_range(0, DAY_SECONDS - 1);
         2: begin
            it.count = DAY_SECONDS * $urandom_range(0, 49709);
            case ($urandom_range(0, 2))
               0: it.count = it.count;
               1: it.count = it.count + 1;
               default: it.count = it.count + DAY_SECONDS - 1;
            endcase
         end
         3: it.count = 32'hFFFFFFFF - $urandom_range(0, 3);
         default: it.count = $urandom_range(DAY_SECONDS, 200000);
      endcase
      // Compare and duration also need A equal to B now and then.
      if (it.command >= CMD_DURATION && it.command <= CMD_COMPARE &&
          $urandom_range(0, 4) == 0) begin
         it.hour_a = it.hour_b;
         it.minute_a = it.minute_b;
         it.second_a = it.second_b;
      end
      return it;
   endfunction

   // Called at a rising edge; returns at the edge where the item is accepted.
   task automatic send_item(input tod_item_type it, input result_type want);
      int unsigned gap;
      gap = sender_gaps ? idle_length() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_hour_a <= it.hour_a;
      req_minute_a <= it.minute_a;
      req_second_a <= it.second_a;
      req_hour_b <= it.hour_b;
      req_minute_b <= it.minute_b;
      req_second_b <= it.second_b;
      req_count <= it.count;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         input_stall_cycles++;
         @(posedge clock);
      end
      expected_results.push_back(want);
      items_sent++;
   endtask

   task automatic send_random_items(input int unsigned num_items);
      tod_item_type it;
      repeat (num_items) begin
         it = random_tod_item();
         send_item(it, predict_tod_result(it));
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
                  expected_results.size());
         $display("time_of_day_alu_unit_tb failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result item with none expected", $time);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("hour_out", want.hour, rsp_hour_out);
            check_field("minute_out", want.minute, rsp_minute_out);
            check_field("second_out", want.second, rsp_second_out);
            check_field("seconds_total", want.secs, rsp_seconds_total);
            check_field("is_equal", want.equal, rsp_is_equal);
            check_field("is_less", want.less, rsp_is_less);
            check_field("is_greater", want.greater, rsp_is_greater);
            check_field("valid_a", want.valid_a, rsp_valid_a);
            results_checked++;
         end
      end
   end

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_off_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            stall_left = receiver_stalls ? idle_length() : 0;
            if (stall_left != 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin
      int unsigned hold_stalls;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int row = 0; row < NUM_DIRECTED; row++) begin
         send_item(directed_rows[row].item,
                   directed_rows[row].typed ? directed_rows[row].want
                                            : predict_tod_result(directed_rows[row].item));
      end
      wait_for_results();

      send_random_items(300);
      wait_for_results();

      // The receiver holds off while items keep coming back to back.
      sender_gaps = 1'b0;
      hold_stalls = input_stall_cycles;
      hold_off_request = 1'b1;
      send_random_items(40);
      hold_stalls = input_stall_cycles - hold_stalls;
      wait_for_results();

      receiver_stalls = 1'b0;
      send_random_items(300);
      wait_for_results();

      sender_gaps = 1'b1;
      receiver_stalls = 1'b1;
      send_random_items(560);
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items (%0d from the directed table) and checked %0d results.",
               items_sent, NUM_DIRECTED, results_checked);
      $display("Input stalled for %0d cycles, %0d of them during the long hold-off.",
               input_stall_cycles, hold_stalls);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("time_of_day_alu_unit_tb passed");
      end else begin
         $display("time_of_day_alu_unit_tb failed");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/tod_alu_pkg.sv
rtl/core/tod_alu_front.sv
rtl/core/tod_alu_exec.sv
rtl/core/tod_alu_split.sv
rtl/core/time_of_day_alu_unit.sv
verif/time_of_day_alu_unit_tb.sv
